// ===== src/mck_pkg.sv =====
// Package for the Morse code keyer: sequencer states, segment request type,
// unit counts and the character-to-code table.
// No dependencies; used by every module in src.
package mck_pkg;

  localparam int unsigned CharW     = 8;
  localparam int unsigned UnitLenW  = 16;
  localparam int unsigned DurW      = 18;
  localparam int unsigned UnitsW    = 3;
  localparam int unsigned MaxElems  = 7;
  localparam int unsigned ElemIdxW  = 3;
  localparam int unsigned TableIdxW = 6;
  localparam int unsigned TdataW    = 24;  // key_on + duration, padded to bytes
  localparam int unsigned PaddrW    = 2;

  localparam logic [UnitLenW-1:0] UnitLenReset = 16'd100;

  // Unit counts of each segment kind
  localparam logic [UnitsW-1:0] DotUnits    = 3'd1;
  localparam logic [UnitsW-1:0] DashUnits   = 3'd3;
  localparam logic [UnitsW-1:0] ElemGapUnits = 3'd1;
  localparam logic [UnitsW-1:0] LetterGapUnits = 3'd2;
  localparam logic [UnitsW-1:0] WordGapUnits = 3'd4;

  // Character codes
  localparam logic [CharW-1:0] CharSpace   = 8'd32;
  localparam logic [CharW-1:0] CharFirst   = 8'd33;   // '!'
  localparam logic [CharW-1:0] CharLast    = 8'd95;   // '_'
  localparam logic [CharW-1:0] CharLowA    = 8'd97;
  localparam logic [CharW-1:0] CharLowZ    = 8'd122;
  localparam logic [CharW-1:0] CaseOffset  = 8'd32;

  // Register addresses
  localparam logic [PaddrW-1:0] AddrUnitLen = 2'd0;

  typedef enum logic [1:0] {
    StIdle,
    StMark,
    StSpace,
    StEnd
  } seq_state_e;

  // One keying segment handed from the sequencer to the duration unit
  typedef struct packed {
    logic              key_on;
    logic [UnitsW-1:0] units;
    logic              last;
  } seg_req_t;

  // Code entry: element count (0 = unmapped) and pattern, first element in
  // bit 6, dash = 1
  typedef struct packed {
    logic [2:0] len;
    logic [MaxElems-1:0] pat;
  } code_t;

  function automatic code_t code_lookup(input logic [TableIdxW-1:0] idx);
    code_t c;
    c = '{len: 3'd0, pat: 7'b0000000};
    case (idx)
      6'd0:  c = '{len: 3'd6, pat: 7'b1010110};  // !
      6'd1:  c = '{len: 3'd6, pat: 7'b0100100};  // "
      6'd3:  c = '{len: 3'd7, pat: 7'b0001001};  // $
      6'd5:  c = '{len: 3'd5, pat: 7'b0100000};  // &
      6'd6:  c = '{len: 3'd6, pat: 7'b0111100};  // '
      6'd7:  c = '{len: 3'd5, pat: 7'b1011000};  // (
      6'd8:  c = '{len: 3'd6, pat: 7'b1011010};  // )
      6'd10: c = '{len: 3'd5, pat: 7'b0101000};  // +
      6'd11: c = '{len: 3'd6, pat: 7'b1100110};  // ,
      6'd12: c = '{len: 3'd6, pat: 7'b1000010};  // -
      6'd13: c = '{len: 3'd6, pat: 7'b0101010};  // .
      6'd14: c = '{len: 3'd5, pat: 7'b1001000};  // /
      6'd15: c = '{len: 3'd5, pat: 7'b1111100};  // 0
      6'd16: c = '{len: 3'd5, pat: 7'b0111100};  // 1
      6'd17: c = '{len: 3'd5, pat: 7'b0011100};  // 2
      6'd18: c = '{len: 3'd5, pat: 7'b0001100};  // 3
      6'd19: c = '{len: 3'd5, pat: 7'b0000100};  // 4
      6'd20: c = '{len: 3'd5, pat: 7'b0000000};  // 5
      6'd21: c = '{len: 3'd5, pat: 7'b1000000};  // 6
      6'd22: c = '{len: 3'd5, pat: 7'b1100000};  // 7
      6'd23: c = '{len: 3'd5, pat: 7'b1110000};  // 8
      6'd24: c = '{len: 3'd5, pat: 7'b1111000};  // 9
      6'd25: c = '{len: 3'd6, pat: 7'b1110000};  // :
      6'd26: c = '{len: 3'd6, pat: 7'b1010100};  // ;
      6'd28: c = '{len: 3'd5, pat: 7'b1000100};  // =
      6'd30: c = '{len: 3'd6, pat: 7'b0011000};  // ?
      6'd31: c = '{len: 3'd6, pat: 7'b0110100};  // @
      6'd32: c = '{len: 3'd2, pat: 7'b0100000};  // A
      6'd33: c = '{len: 3'd4, pat: 7'b1000000};  // B
      6'd34: c = '{len: 3'd4, pat: 7'b1010000};  // C
      6'd35: c = '{len: 3'd3, pat: 7'b1000000};  // D
      6'd36: c = '{len: 3'd1, pat: 7'b0000000};  // E
      6'd37: c = '{len: 3'd4, pat: 7'b0010000};  // F
      6'd38: c = '{len: 3'd3, pat: 7'b1100000};  // G
      6'd39: c = '{len: 3'd4, pat: 7'b0000000};  // H
      6'd40: c = '{len: 3'd2, pat: 7'b0000000};  // I
      6'd41: c = '{len: 3'd4, pat: 7'b0111000};  // J
      6'd42: c = '{len: 3'd3, pat: 7'b1010000};  // K
      6'd43: c = '{len: 3'd4, pat: 7'b0100000};  // L
      6'd44: c = '{len: 3'd2, pat: 7'b1100000};  // M
      6'd45: c = '{len: 3'd2, pat: 7'b1000000};  // N
      6'd46: c = '{len: 3'd3, pat: 7'b1110000};  // O
      6'd47: c = '{len: 3'd4, pat: 7'b0110000};  // P
      6'd48: c = '{len: 3'd4, pat: 7'b1101000};  // Q
      6'd49: c = '{len: 3'd3, pat: 7'b0100000};  // R
      6'd50: c = '{len: 3'd3, pat: 7'b0000000};  // S
      6'd51: c = '{len: 3'd1, pat: 7'b1000000};  // T
      6'd52: c = '{len: 3'd3, pat: 7'b0010000};  // U
      6'd53: c = '{len: 3'd4, pat: 7'b0001000};  // V
      6'd54: c = '{len: 3'd3, pat: 7'b0110000};  // W
      6'd55: c = '{len: 3'd4, pat: 7'b1001000};  // X
      6'd56: c = '{len: 3'd4, pat: 7'b1011000};  // Y
      6'd57: c = '{len: 3'd4, pat: 7'b1100000};  // Z
      6'd62: c = '{len: 3'd6, pat: 7'b0011010};  // _
      default: c = '{len: 3'd0, pat: 7'b0000000};
    endcase
    return c;
  endfunction

endpackage

// ===== src/morse_code_keyer_unit.sv =====
// Morse code keyer, top level: APB register, sequencer, duration unit and
// output register. Depends on mck_pkg, mck_seq and mck_dur.
//
// Usage:
//   s_axis: one ASCII character per transfer in tdata[7:0]. Lowercase is
//   folded to uppercase; characters without a code are taken and dropped.
//   m_axis: one keying segment per transfer, tdata[0] = key_on,
//   tdata[18:1] = duration in ticks, tlast marks the character's final gap.
//   APB: unit length at byte address 0 (reset 100), write only while idle.
// Timing:
//   Between the input transfer and the first valid segment lie the sequencer
//   state register and the output register. With an always-ready receiver a
//   character of n elements gives 2n+1 segments on consecutive cycles; the
//   next input transfer is taken only once the sequencer is back in idle.
//   Each segment's duration comes from one pass through the shared shift-add
//   unit, one segment per cycle while m_axis_tready is high.
// Reset and stall:
//   Reset empties the output register, returns the sequencer to idle and
//   sets the unit length to 100. While m_axis_tready is low the segment
//   holds in the output register and the sequencer waits.
module morse_code_keyer_unit (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // APB configuration port
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [mck_pkg::PaddrW-1:0]  paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  // Input characters
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  input  logic [7:0]                  s_axis_tdata,   // [7:0] character
  // Output segments
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  output logic [mck_pkg::TdataW-1:0]  m_axis_tdata,   // [0] key_on, [18:1] duration
  output logic                        m_axis_tlast    // last
);

  logic [mck_pkg::UnitLenW-1:0] unit_len_q;
  logic                         cfg_wr;
  logic                         in_xfer;
  logic                         adv;
  logic                         seq_idle;
  logic                         seg_valid;
  mck_pkg::seg_req_t            seg;
  logic [mck_pkg::DurW-1:0]     seg_dur;

  logic                         out_valid_q;
  logic                         out_key_q;
  logic [mck_pkg::DurW-1:0]     out_dur_q;
  logic                         out_last_q;

  // Configuration register
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr == mck_pkg::AddrUnitLen);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      unit_len_q <= mck_pkg::UnitLenReset;
    end else if (cfg_wr) begin
      unit_len_q <= pwdata[mck_pkg::UnitLenW-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr == mck_pkg::AddrUnitLen) begin
      prdata = {16'd0, unit_len_q};
    end
  end

  // Handshakes
  assign s_axis_tready = seq_idle;
  assign in_xfer       = s_axis_tvalid && seq_idle;
  assign adv           = !out_valid_q || m_axis_tready;

  mck_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_xfer_i   (in_xfer),
    .in_char_i   (s_axis_tdata),
    .adv_i       (adv),
    .idle_o      (seq_idle),
    .seg_valid_o (seg_valid),
    .seg_o       (seg)
  );

  mck_dur u_dur (
    .units_i    (seg.units),
    .unit_len_i (unit_len_q),
    .duration_o (seg_dur)
  );

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= seg_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && seg_valid) begin
      out_key_q  <= seg.key_on;
      out_dur_q  <= seg_dur;
      out_last_q <= seg.last;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {5'd0, out_dur_q, out_key_q};
  assign m_axis_tlast  = out_last_q;

`ifndef NO_ASSERTIONS
  // A key-on segment never ends a character
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && out_key_q) |-> !out_last_q)
    else $error("key-on segment marked last");

  // A key-on segment lasts one or three units
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && out_key_q) |->
      (out_dur_q == {2'b00, unit_len_q}) ||
      (out_dur_q == ({2'b00, unit_len_q} + {1'b0, unit_len_q, 1'b0})))
    else $error("key-on duration is not a dot or a dash");

  // A space keeps the block busy for its word gap
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_xfer && (s_axis_tdata == mck_pkg::CharSpace)) |=> (!s_axis_tready && seg_valid))
    else $error("space produced no word gap");
`endif

endmodule

// ===== src/mck_dur.sv =====
// Shared duration unit: segment unit count times the unit length.
// Shift-and-add over the three unit-count bits; depends on mck_pkg.
module mck_dur (
  input  logic [mck_pkg::UnitsW-1:0]   units_i,
  input  logic [mck_pkg::UnitLenW-1:0] unit_len_i,
  output logic [mck_pkg::DurW-1:0]     duration_o
);

  logic [mck_pkg::DurW-1:0] term0, term1, term2;

  // Partial products for unit counts 1, 2 and 4
  assign term0 = {2'b00, unit_len_i} & {mck_pkg::DurW{units_i[0]}};
  assign term1 = {1'b0, unit_len_i, 1'b0} & {mck_pkg::DurW{units_i[1]}};
  assign term2 = {unit_len_i, 2'b00} & {mck_pkg::DurW{units_i[2]}};

  assign duration_o = term0 + term1 + term2;

endmodule

// ===== src/mck_seq.sv =====
// Segment sequencer: looks up the character and walks its elements, one
// segment per step, while the output side can take it. Depends on mck_pkg.
module mck_seq (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_xfer_i,
  input  logic [mck_pkg::CharW-1:0] in_char_i,
  input  logic                      adv_i,
  output logic                      idle_o,
  output logic                      seg_valid_o,
  output mck_pkg::seg_req_t         seg_o
);

  mck_pkg::seq_state_e state_q, state_d;
  mck_pkg::code_t      code_q, code_d;
  logic [mck_pkg::ElemIdxW-1:0] idx_q, idx_d;
  logic                         word_q, word_d;

  logic [mck_pkg::CharW-1:0] char_fold;
  logic [mck_pkg::CharW-1:0] char_off;
  mck_pkg::code_t            code_lu;
  logic                      in_table;

  // Case folding and table lookup of the incoming character
  always_comb begin
    if (in_char_i inside {[mck_pkg::CharLowA:mck_pkg::CharLowZ]}) begin
      char_fold = in_char_i - mck_pkg::CaseOffset;
    end else begin
      char_fold = in_char_i;
    end
    in_table = char_fold inside {[mck_pkg::CharFirst:mck_pkg::CharLast]};
    char_off = char_fold - mck_pkg::CharFirst;
    code_lu  = mck_pkg::code_lookup(char_off[mck_pkg::TableIdxW-1:0]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mck_pkg::StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    code_q <= code_d;
    idx_q  <= idx_d;
    word_q <= word_d;
  end

  // Next state and segment request
  always_comb begin
    state_d     = state_q;
    code_d      = code_q;
    idx_d       = idx_q;
    word_d      = word_q;
    idle_o      = 1'b0;
    seg_valid_o = 1'b0;
    seg_o       = '{key_on: 1'b0, units: mck_pkg::ElemGapUnits, last: 1'b0};
    case (state_q)
      mck_pkg::StIdle: begin
        idle_o = 1'b1;
        if (in_xfer_i) begin
          idx_d  = '0;
          code_d = code_lu;
          if (in_char_i == mck_pkg::CharSpace) begin
            word_d  = 1'b1;
            state_d = mck_pkg::StEnd;
          end else if (in_table && (code_lu.len != 3'd0)) begin
            word_d  = 1'b0;
            state_d = mck_pkg::StMark;
          end
        end
      end
      mck_pkg::StMark: begin
        seg_valid_o  = 1'b1;
        seg_o.key_on = 1'b1;
        seg_o.units  = code_q.pat[3'd6 - idx_q] ? mck_pkg::DashUnits : mck_pkg::DotUnits;
        if (adv_i) begin
          state_d = mck_pkg::StSpace;
        end
      end
      mck_pkg::StSpace: begin
        seg_valid_o = 1'b1;
        if (adv_i) begin
          if (idx_q + 3'd1 == code_q.len) begin
            state_d = mck_pkg::StEnd;
          end else begin
            idx_d   = idx_q + 3'd1;
            state_d = mck_pkg::StMark;
          end
        end
      end
      mck_pkg::StEnd: begin
        seg_valid_o = 1'b1;
        seg_o.units = word_q ? mck_pkg::WordGapUnits : mck_pkg::LetterGapUnits;
        seg_o.last  = 1'b1;
        if (adv_i) begin
          state_d = mck_pkg::StIdle;
        end
      end
      default: begin
        state_d = mck_pkg::StIdle;
      end
    endcase
  end

endmodule
